// File: design/lsdf_pkg.sv
// ----------------------------------------------------------------------------
// lsdf_pkg
// Shared types and constants of the LSB steganography deframer.
// ----------------------------------------------------------------------------
package lsdf_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_EXT_CHAR  = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_MAGIC_BAD = 3'd2,
    KIND_EXT_LEN   = 3'd3,
    KIND_FILE_SIZE = 3'd4,
    KIND_EXT_LONG  = 3'd5
  } kind_e;

  // configuration register indexes
  localparam logic [1:0] CFG_HEADER_SKIP = 2'd0;
  localparam logic [1:0] CFG_MAGIC_LEN   = 2'd1;
  localparam logic [1:0] CFG_MAGIC_WORD  = 2'd2;

  // configuration reset values
  localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
  localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;
  localparam logic [63:0] MAGIC_WORD_RST  = 64'd8998;

  // longest extension accepted
  localparam logic [31:0] EXT_MAX = 32'd16;

  // input item
  typedef struct packed {
    logic [7:0] carrier_byte;
    logic       start_of_file;
  } in_item_t;

  // result item
  typedef struct packed {
    kind_e       result_kind;
    logic [31:0] result_value;
    logic        message_end;
  } out_item_t;

  // completed word as classified by the front
  typedef struct packed {
    logic        is_magic;   // magic character, checked in the back
    logic        first;      // first magic character of a frame
    logic        last;       // last magic character of a frame
    logic [2:0]  sel;        // byte of the magic word to compare against
    kind_e       kind;       // result kind for non-magic words
    logic [31:0] word;
    logic        msg_end;
  } event_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: design/lsdf_stream_if.sv
// ----------------------------------------------------------------------------
// lsdf_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface lsdf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/lsdf_front.sv
// ----------------------------------------------------------------------------
// lsdf_front
// Header skip, LSB gathering and frame sequencing; pushes completed words.
// ----------------------------------------------------------------------------
module lsdf_front
  import lsdf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  lsdf_stream_if.sink  carrier_i,
  input  logic [7:0]   header_skip_i,
  input  logic [3:0]   magic_len_i,
  input  logic         q_full_i,
  output logic         push_o,
  output event_t       ev_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_MAGIC  = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_EXT    = 3'd3,
    PH_FSIZE  = 3'd4,
    PH_DATA   = 3'd5,
    PH_IDLE   = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  hcnt_q, hcnt_d;
  logic [4:0]  bcnt_q, bcnt_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] left_q, left_d;
  logic [2:0]  midx_q, midx_d;

  logic        accept;
  logic        run;
  logic        need32;
  logic        word_done;
  logic [31:0] shifted;
  logic [31:0] word;
  logic [31:0] count;
  logic [31:0] left_m1;
  logic [3:0]  len_eff;
  logic [3:0]  midx_inc;
  logic [2:0]  mpos;

  // take a byte whenever the queue has room
  assign carrier_i.ready = ~q_full_i;
  assign accept          = carrier_i.valid & carrier_i.ready;

  // magic length clamped to 1..8
  always_comb begin
    if (magic_len_i == 4'd0) begin
      len_eff = 4'd1;
    end else if (magic_len_i > 4'd8) begin
      len_eff = 4'd8;
    end else begin
      len_eff = magic_len_i;
    end
  end

  // per-byte sequencing
  always_comb begin
    phase_d   = phase_q;
    hcnt_d    = hcnt_q;
    bcnt_d    = bcnt_q;
    shift_d   = shift_q;
    left_d    = left_q;
    midx_d    = midx_q;
    push_o    = 1'b0;
    ev_o      = '0;
    run       = 1'b0;
    need32    = 1'b0;
    word_done = 1'b0;
    shifted   = '0;
    word      = '0;
    count     = '0;
    left_m1   = '0;
    midx_inc  = '0;
    mpos      = '0;

    if (accept) begin
      // new image restarts everything
      if (carrier_i.payload.start_of_file) begin
        phase_d = PH_HEADER;
        hcnt_d  = '0;
        bcnt_d  = '0;
        shift_d = '0;
        left_d  = '0;
        midx_d  = '0;
      end

      // header skip; the first byte past it is already a carrier
      run = 1'b1;
      if (phase_d == PH_HEADER) begin
        if (hcnt_d < header_skip_i) begin
          hcnt_d = hcnt_d + 8'd1;
          run    = 1'b0;
        end else begin
          phase_d = PH_MAGIC;
          midx_d  = '0;
          bcnt_d  = '0;
          shift_d = '0;
        end
      end
      if (phase_d == PH_IDLE) begin
        run = 1'b0;
      end

      // bit gathering
      if (run) begin
        need32    = (phase_d == PH_EXTLEN) || (phase_d == PH_FSIZE);
        shifted   = {shift_d[30:0], carrier_i.payload.carrier_byte[0]};
        word_done = need32 ? (bcnt_d == 5'd31) : (bcnt_d == 5'd7);
        if (!word_done) begin
          bcnt_d  = bcnt_d + 5'd1;
          shift_d = shifted;
        end else begin
          bcnt_d  = '0;
          shift_d = '0;
        end
        word    = need32 ? shifted : {24'd0, shifted[7:0]};
        count   = word[31] ? 32'd0 : word;
        left_m1 = left_d - 32'd1;
      end

      // frame sequencing on a completed word
      if (word_done) begin
        push_o    = 1'b1;
        ev_o.word = word;
        case (phase_d)
          PH_MAGIC: begin
            // a length cut below the index compares the last used character
            midx_inc      = {1'b0, midx_d} + 4'd1;
            mpos          = ({1'b0, midx_d} < len_eff) ? midx_d : 3'(len_eff - 4'd1);
            ev_o.is_magic = 1'b1;
            ev_o.first    = (midx_d == 3'd0);
            ev_o.last     = (midx_inc >= len_eff);
            ev_o.sel      = 3'(len_eff - 4'd1 - {1'b0, mpos});
            midx_d        = midx_d + 3'd1;
            if (ev_o.last) begin
              phase_d = PH_EXTLEN;
            end
          end
          PH_EXTLEN: begin
            if (count > EXT_MAX) begin
              ev_o.kind    = KIND_EXT_LONG;
              ev_o.msg_end = 1'b1;
              phase_d      = PH_IDLE;
            end else begin
              ev_o.kind = KIND_EXT_LEN;
              left_d    = count;
              phase_d   = (count == 32'd0) ? PH_FSIZE : PH_EXT;
            end
          end
          PH_EXT: begin
            ev_o.kind = KIND_EXT_CHAR;
            left_d    = left_m1;
            if (left_m1 == 32'd0) begin
              phase_d = PH_FSIZE;
            end
          end
          PH_FSIZE: begin
            ev_o.kind = KIND_FILE_SIZE;
            left_d    = count;
            if (count == 32'd0) begin
              ev_o.msg_end = 1'b1;
              phase_d      = PH_IDLE;
            end else begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            ev_o.kind = KIND_DATA;
            left_d    = left_m1;
            if (left_m1 == 32'd0) begin
              ev_o.msg_end = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
          default: begin
            push_o = 1'b0;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hcnt_q  <= '0;
      bcnt_q  <= '0;
      shift_q <= '0;
      left_q  <= '0;
      midx_q  <= '0;
    end else begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      bcnt_q  <= bcnt_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      midx_q  <= midx_d;
    end
  end

endmodule

// File: design/lsdf_queue.sv
// ----------------------------------------------------------------------------
// lsdf_queue
// Small first-in first-out queue of word events between front and back.
// ----------------------------------------------------------------------------
module lsdf_queue
  import lsdf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  event_t    data_i,
  input  logic      pop_i,
  output event_t    data_o,
  output q_status_t status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  event_t          entry_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [AW:0]     cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign data_o         = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW + 1)'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - (AW + 1)'(1);
      end
    end
  end

endmodule

// File: design/lsdf_back.sv
// ----------------------------------------------------------------------------
// lsdf_back
// Magic check, error squashing and the registered result stage.
// ----------------------------------------------------------------------------
module lsdf_back
  import lsdf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  event_t         ev_i,
  input  logic           q_empty_i,
  input  logic [63:0]    magic_word_i,
  output logic           pop_o,
  lsdf_stream_if.source  result_o
);

  logic      out_valid_q;
  out_item_t out_q;
  logic      bad_q, bad_d;
  logic      mismatch;
  logic      emit;
  logic [7:0] expect_char;

  // take the next event when the result register is free or being drained
  assign pop_o = ~q_empty_i & (~out_valid_q | result_o.ready);

  // magic character compare
  assign expect_char = magic_word_i[8*ev_i.sel +: 8];
  assign mismatch    = (ev_i.word[7:0] != expect_char);

  // error tracking and result decision
  always_comb begin
    bad_d = bad_q;
    emit  = 1'b0;
    if (ev_i.is_magic) begin
      bad_d = (ev_i.first ? 1'b0 : bad_q) | mismatch;
      emit  = ev_i.last & bad_d;
    end else begin
      emit = ~bad_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        bad_q       <= bad_d;
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      if (ev_i.is_magic) begin
        out_q.result_kind  <= KIND_MAGIC_BAD;
        out_q.result_value <= '0;
        out_q.message_end  <= 1'b1;
      end else begin
        out_q.result_kind  <= ev_i.kind;
        out_q.result_value <= ev_i.word;
        out_q.message_end  <= ev_i.msg_end;
      end
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

// File: design/lsb_stego_deframer_unit.sv
// ----------------------------------------------------------------------------
// lsb_stego_deframer_unit
// LSB steganography deframer: skips the image header, gathers carrier LSBs
// and returns magic/ext-length errors, lengths, ext chars and data bytes.
//
//   channel    dir  payload                                    handshake
//   carrier_i  in   carrier_byte[7:0], start_of_file           valid/ready
//   result_o   out  result_kind[2:0], result_value[31:0],      valid/ready
//                   message_end
//   cfg_*      in   cfg_idx_i[1:0], cfg_data_i[63:0]           cfg_we_i
//
// One carrier byte per cycle while the queue has room; a completed word
// passes through the word queue and the registered result stage.
// The front stalls only when the QUEUE_DEPTH-entry word queue is full, and
// the back stalls only on a held result. Reset is asynchronous, active low,
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module lsb_stego_deframer_unit
  import lsdf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsdf_stream_if.sink   carrier_i,
  lsdf_stream_if.source result_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i
);

  logic [7:0]  header_skip_q;
  logic [3:0]  magic_len_q;
  logic [63:0] magic_word_q;

  logic        push;
  logic        pop;
  event_t      ev_in, ev_out;
  q_status_t   q_status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_skip_q <= HEADER_SKIP_RST;
      magic_len_q   <= MAGIC_LEN_RST;
      magic_word_q  <= MAGIC_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER_SKIP: header_skip_q <= cfg_data_i[7:0];
        CFG_MAGIC_LEN:   magic_len_q   <= cfg_data_i[3:0];
        CFG_MAGIC_WORD:  magic_word_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front: header skip and word gathering
  lsdf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .carrier_i     (carrier_i),
    .header_skip_i (header_skip_q),
    .magic_len_i   (magic_len_q),
    .q_full_i      (q_status.full),
    .push_o        (push),
    .ev_o          (ev_in)
  );

  // word queue
  lsdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (ev_in),
    .pop_i    (pop),
    .data_o   (ev_out),
    .status_o (q_status)
  );

  // back: magic check and results
  lsdf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_i         (ev_out),
    .q_empty_i    (q_status.empty),
    .magic_word_i (magic_word_q),
    .pop_o        (pop),
    .result_o     (result_o)
  );

`ifndef SYNTHESIS
  // the front never produces a word into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("word pushed into full queue");

  // extension characters and accepted lengths never end a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !(result_o.payload.message_end &&
      (result_o.payload.result_kind == KIND_EXT_CHAR ||
       result_o.payload.result_kind == KIND_EXT_LEN)))
    else $error("message end on a non-final result kind");

  // a magic error always ends the message with a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.payload.result_kind == KIND_MAGIC_BAD) |->
      (result_o.payload.message_end && result_o.payload.result_value == 32'd0))
    else $error("malformed magic error result");

  // a popped event always comes from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule
